// File: rtl/psd_pkg.sv
// Shared types and constants for the proportional steering PWM drive.
package psd_pkg;

  localparam int unsigned AngleW = 16;
  localparam int unsigned ErrW   = 17;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DutyW  = 8;
  localparam int unsigned PwmW   = 10;
  localparam int unsigned DriveW = 9;
  localparam int unsigned ProdW  = 32;
  localparam int unsigned MagW   = 9;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  // The gain is Q8.8 and the error is in hundredths, so the drive is product / (256 * 100).
  // After the shift by eight, a quotient of 256 or more already exceeds any limit.
  localparam logic [ProdW-9:0] ScaleSat      = 24'd25600;
  localparam logic [14:0]      Recip100      = 15'd20972;
  localparam int unsigned      Recip100Shift = 21;
  localparam logic [MagW-1:0]  MagSat        = 9'd256;

  localparam logic signed [DriveW-1:0] ValveMax = 9'sd250;
  localparam logic signed [DriveW-1:0] ValveMin = -9'sd250;
  localparam logic signed [DriveW-1:0] ValveMid = 9'sd128;
  localparam logic [PwmW-1:0]          PwmFull  = 10'd1023;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_LOW_DUTY    = 3'd1,
    CFG_HIGH_DUTY   = 3'd2,
    CFG_MIN_DUTY    = 3'd3,
    CFG_INVERT      = 3'd4,
    CFG_VALVE_MODE  = 3'd5,
    CFG_DIR_PWM     = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [GainW-1:0] gain;
    logic [DutyW-1:0] low_duty;
    logic [DutyW-1:0] high_duty;
    logic [DutyW-1:0] min_duty;
    logic             invert_direction;
    logic             valve_mode;
    logic             dir_plus_pwm_driver;
  } cfg_t;

  typedef struct packed {
    logic signed [AngleW-1:0] actual_angle;
    logic signed [AngleW-1:0] target_angle;
    logic                     steer_on;
  } in_beat_t;

  typedef struct packed {
    logic [ProdW-1:0] prod;
    logic             neg;
    logic             out_band;
    logic             steer_on;
  } front_t;

  typedef struct packed {
    logic [MagW-1:0]  mag;
    logic [DutyW-1:0] lim;
    logic             neg;
    logic             steer_on;
  } scale_t;

  typedef struct packed {
    logic                     enable_pin;
    logic [PwmW-1:0]          left_duty;
    logic [PwmW-1:0]          right_duty;
    logic [DutyW-1:0]         duty_display;
    logic signed [DriveW-1:0] drive_value;
  } out_beat_t;

endpackage

// File: rtl/psd_in_if.sv
// Input channel carrying the angle pair and the steering enable.
interface psd_in_if import psd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [AngleW-1:0] actual_angle;
  logic signed [AngleW-1:0] target_angle;
  logic                     steer_on;

  modport source (output valid, output actual_angle, output target_angle, output steer_on,
                  input ready);
  modport sink   (input valid, input actual_angle, input target_angle, input steer_on,
                  output ready);
endinterface

// File: rtl/psd_out_if.sv
// Output channel carrying the enable level, the two duties, the display and the drive.
interface psd_out_if import psd_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     enable_pin;
  logic [PwmW-1:0]          left_duty;
  logic [PwmW-1:0]          right_duty;
  logic [DutyW-1:0]         duty_display;
  logic signed [DriveW-1:0] drive_value;

  modport source (output valid, output enable_pin, output left_duty, output right_duty,
                  output duty_display, output drive_value, input ready);
  modport sink   (input valid, input enable_pin, input left_duty, input right_duty,
                  input duty_display, input drive_value, output ready);
endinterface

// File: rtl/proportional_steer_pwm_drive_core.sv
// Proportional steering drive with a ramped PWM limit and held dual or direction PWM outputs.
// Four register stages: input, error and gain product, reciprocal scaling, output drive.
// A result passes the input, error, scaling and output registers in turn. One beat per cycle
// is sustained while out_ch.ready is high, and each stage advances on its own whenever the
// stage after it has room. Reset clears the pipeline, the enable level and the held duties,
// and loads the register defaults (high_duty at 255, all else zero).
module proportional_steer_pwm_drive_core import psd_pkg::*; #(
  parameter int unsigned RAMP_DEGREES = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  psd_in_if.sink              in_ch,
  psd_out_if.source           out_ch
);

  localparam int unsigned Band  = RAMP_DEGREES * 100;
  localparam int unsigned RampW = $clog2(Band) + DutyW;

  cfg_t             cfg_q;
  in_beat_t         in_q;
  logic             v1_q, v2_q, v3_q, v4_q;
  logic             rdy1, rdy2, rdy3, rdy4;
  front_t           front;
  logic [RampW-1:0] ramp;
  scale_t           scale;
  out_beat_t        beat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain                <= '0;
      cfg_q.low_duty            <= '0;
      cfg_q.high_duty           <= '1;
      cfg_q.min_duty            <= '0;
      cfg_q.invert_direction    <= 1'b0;
      cfg_q.valve_mode          <= 1'b0;
      cfg_q.dir_plus_pwm_driver <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_GAIN:       cfg_q.gain                <= cfg_wdata_i;
        CFG_LOW_DUTY:   cfg_q.low_duty            <= cfg_wdata_i[DutyW-1:0];
        CFG_HIGH_DUTY:  cfg_q.high_duty           <= cfg_wdata_i[DutyW-1:0];
        CFG_MIN_DUTY:   cfg_q.min_duty            <= cfg_wdata_i[DutyW-1:0];
        CFG_INVERT:     cfg_q.invert_direction    <= cfg_wdata_i[0];
        CFG_VALVE_MODE: cfg_q.valve_mode          <= cfg_wdata_i[0];
        CFG_DIR_PWM:    cfg_q.dir_plus_pwm_driver <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Each stage takes a new beat when it is empty or its own beat moves on.
  assign rdy4 = !v4_q || out_ch.ready;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ch.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_ch.valid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && in_ch.valid) begin
      in_q.actual_angle <= in_ch.actual_angle;
      in_q.target_angle <= in_ch.target_angle;
      in_q.steer_on     <= in_ch.steer_on;
    end
  end

  psd_front #(
    .RAMP_DEGREES(RAMP_DEGREES)
  ) u_front (
    .clk_i   (clk_i),
    .en_i    (rdy2 && v1_q),
    .beat_i  (in_q),
    .cfg_i   (cfg_q),
    .front_o (front),
    .ramp_o  (ramp)
  );

  psd_scale #(
    .RAMP_DEGREES(RAMP_DEGREES)
  ) u_scale (
    .clk_i   (clk_i),
    .en_i    (rdy3 && v2_q),
    .front_i (front),
    .ramp_i  (ramp),
    .cfg_i   (cfg_q),
    .scale_o (scale)
  );

  // The held outputs change only when a beat enters the output stage.
  psd_drive u_drive (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (rdy4 && v3_q),
    .scale_i (scale),
    .cfg_i   (cfg_q),
    .beat_o  (beat)
  );

  assign out_ch.valid        = v4_q;
  assign out_ch.enable_pin   = beat.enable_pin;
  assign out_ch.left_duty    = beat.left_duty;
  assign out_ch.right_duty   = beat.right_duty;
  assign out_ch.duty_display = beat.duty_display;
  assign out_ch.drive_value  = beat.drive_value;

endmodule

// File: rtl/psd_front.sv
// Error stage: angle error, gain product and ramp numerator.
module psd_front import psd_pkg::*; #(
  parameter int unsigned RAMP_DEGREES = 3,
  localparam int unsigned Band = RAMP_DEGREES * 100,
  localparam int unsigned AbsW = $clog2(Band),
  localparam int unsigned RampW = AbsW + DutyW
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  in_beat_t         beat_i,
  input  cfg_t             cfg_i,
  output front_t           front_o,
  output logic [RampW-1:0] ramp_o
);

  logic signed [ErrW-1:0] err;
  logic [ErrW-1:0]        abs_err;
  logic [ProdW-1:0]       prod;
  logic                   desc;
  logic [DutyW-1:0]       span;
  logic [RampW-1:0]       ramp_t;
  front_t                 front_d;
  logic [RampW-1:0]       ramp_d;
  front_t                 front_q;
  logic [RampW-1:0]       ramp_q;

  always_comb begin
    err     = ErrW'(beat_i.actual_angle) - ErrW'(beat_i.target_angle);
    abs_err = err[ErrW-1] ? ErrW'(-err) : ErrW'(err);
    prod    = ProdW'(cfg_i.gain) * ProdW'(abs_err);
    desc    = cfg_i.high_duty < cfg_i.low_duty;
    span    = desc ? (cfg_i.low_duty - cfg_i.high_duty) : (cfg_i.high_duty - cfg_i.low_duty);
    ramp_t  = RampW'(abs_err[AbsW-1:0]) * RampW'(span);
    // A descending ramp rounds the step up, so that the limit floors correctly.
    ramp_d  = desc ? (ramp_t + RampW'(Band - 1)) : ramp_t;
    front_d.prod     = prod;
    front_d.neg      = err[ErrW-1];
    front_d.out_band = abs_err >= ErrW'(Band);
    front_d.steer_on = beat_i.steer_on;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      front_q <= front_d;
      ramp_q  <= ramp_d;
    end
  end

  assign front_o = front_q;
  assign ramp_o  = ramp_q;

endmodule

// File: rtl/psd_scale.sv
// Scale stage: constant divisions by reciprocal products and the ramped limit.
module psd_scale import psd_pkg::*; #(
  parameter int unsigned RAMP_DEGREES = 3,
  localparam int unsigned Band = RAMP_DEGREES * 100,
  localparam int unsigned AbsW = $clog2(Band),
  localparam int unsigned RampW = AbsW + DutyW,
  localparam longint unsigned BandSq = longint'(Band) * longint'(Band) * 256,
  localparam int unsigned RecipShift = $clog2(BandSq),
  localparam longint unsigned RecipBand = ((64'd1 << RecipShift) + Band - 1) / Band,
  localparam int unsigned RecipW = $clog2(RecipBand + 1),
  localparam int unsigned RpW = RampW + RecipW + 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  front_t           front_i,
  input  logic [RampW-1:0] ramp_i,
  input  cfg_t             cfg_i,
  output scale_t           scale_o
);

  logic [ProdW-9:0] shifted;
  logic             big;
  logic [29:0]      qp;
  logic [RpW-1:0]   rp;
  logic [DutyW-1:0] step;
  scale_t           scale_d;
  scale_t           scale_q;

  always_comb begin
    shifted = front_i.prod[ProdW-1:8];
    big     = shifted >= ScaleSat;
    qp      = 30'(shifted[14:0]) * 30'(Recip100);
    rp      = RpW'(ramp_i) * RpW'(RecipBand[RecipW-1:0]);
    step    = rp[RecipShift +: DutyW];
    scale_d.mag = big ? MagSat : {1'b0, qp[Recip100Shift +: DutyW]};
    if (front_i.out_band) begin
      scale_d.lim = cfg_i.high_duty;
    end else if (cfg_i.high_duty < cfg_i.low_duty) begin
      scale_d.lim = cfg_i.low_duty - step;
    end else begin
      scale_d.lim = cfg_i.low_duty + step;
    end
    scale_d.neg      = front_i.neg;
    scale_d.steer_on = front_i.steer_on;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      scale_q <= scale_d;
    end
  end

  assign scale_o = scale_q;

endmodule

// File: rtl/psd_drive.sv
// Drive stage: kick, limit, inversion, valve mapping and the held PWM outputs.
module psd_drive import psd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  scale_t    scale_i,
  input  cfg_t      cfg_i,
  output out_beat_t beat_o
);

  logic [PwmW-1:0]          kicked;
  logic [DutyW-1:0]         clamped;
  logic                     neg;
  logic signed [DriveW-1:0] drive_lim;
  logic signed [DriveW-1:0] valve_clip;
  logic signed [DriveW-1:0] drive;
  logic [DriveW-1:0]        neg_drive;
  logic [DutyW-1:0]         mag;
  logic [PwmW-1:0]          pwm;

  logic                     was_en_d, was_en_q;
  logic [PwmW-1:0]          left_d, left_q;
  logic [PwmW-1:0]          right_d, right_q;
  logic [DutyW-1:0]         disp_d, disp_q;
  logic signed [DriveW-1:0] drive_q;

  always_comb begin
    kicked  = PwmW'(scale_i.mag) + ((scale_i.mag != '0) ? PwmW'(cfg_i.min_duty) : '0);
    clamped = (kicked > PwmW'(scale_i.lim)) ? scale_i.lim : kicked[DutyW-1:0];
    neg     = scale_i.neg ^ cfg_i.invert_direction;
    drive_lim = neg ? -$signed({1'b0, clamped}) : $signed({1'b0, clamped});

    if (drive_lim > ValveMax) begin
      valve_clip = ValveMax;
    end else if (drive_lim < ValveMin) begin
      valve_clip = ValveMin;
    end else begin
      valve_clip = drive_lim;
    end
    drive = cfg_i.valve_mode ? ((valve_clip >>> 2) + ValveMid) : drive_lim;

    neg_drive = DriveW'(-drive);
    mag = drive[DriveW-1] ? neg_drive[DutyW-1:0] : drive[DutyW-1:0];
    pwm = {mag, 2'b00};

    was_en_d = was_en_q;
    left_d   = left_q;
    right_d  = right_q;
    disp_d   = disp_q;
    if (was_en_q && !scale_i.steer_on) begin
      was_en_d = 1'b0;
      left_d   = '0;
      right_d  = '0;
      disp_d   = '0;
    end else if (scale_i.steer_on) begin
      was_en_d = 1'b1;
    end

    if (scale_i.steer_on) begin
      disp_d = mag;
      if (cfg_i.dir_plus_pwm_driver) begin
        left_d  = drive[DriveW-1] ? '0 : PwmFull;
        right_d = pwm;
      end else if (drive > 0) begin
        left_d  = pwm;
        right_d = '0;
      end else begin
        left_d  = '0;
        right_d = pwm;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      was_en_q <= 1'b0;
      left_q   <= '0;
      right_q  <= '0;
      disp_q   <= '0;
    end else if (en_i) begin
      was_en_q <= was_en_d;
      left_q   <= left_d;
      right_q  <= right_d;
      disp_q   <= disp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drive_q <= drive;
    end
  end

  assign beat_o.enable_pin   = was_en_q;
  assign beat_o.left_duty    = left_q;
  assign beat_o.right_duty   = right_q;
  assign beat_o.duty_display = disp_q;
  assign beat_o.drive_value  = drive_q;

endmodule

// File: verif/proportional_steer_pwm_drive_core_tb.sv
// Self-checking testbench for the proportional steering PWM drive core.
`timescale 1ns / 1ps

module proportional_steer_pwm_drive_core_tb;
  import psd_pkg::*;

  localparam int unsigned RampDegrees = 3;
  localparam longint      Band        = RampDegrees * 100;
  localparam int          NumPhases   = 8;
  localparam int          PhaseBeats  = 191;
  localparam int          HoldCycles  = 300;
  localparam int          CycleLimit  = 600000;

  typedef struct {
    cfg_t      cfg;
    in_beat_t  beat;
    bit        typed;
    out_beat_t want;
  } stim_row_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;

  psd_in_if  in_ch ();
  psd_out_if out_ch ();

  proportional_steer_pwm_drive_core #(
    .RAMP_DEGREES(RampDegrees)
  ) dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Predictor copy of the registers and the held outputs.
  cfg_t             model_cfg;
  logic             en_q;
  logic [PwmW-1:0]  left_q;
  logic [PwmW-1:0]  right_q;
  logic [DutyW-1:0] disp_q;

  out_beat_t drive_q[$];
  stim_row_t directed_rows[$];

  int err_cnt;
  int result_cnt;
  int cycle_cnt;
  int idle_pct;
  bit quiet;
  int hold_req;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic out_beat_t drive_predict(in_beat_t b);
    longint    err;
    longint    drv;
    longint    mag_err;
    longint    lim;
    longint    mag;
    out_beat_t r;
    if (en_q && !b.steer_on) begin
      en_q    = 1'b0;
      left_q  = '0;
      right_q = '0;
      disp_q  = '0;
    end else if (b.steer_on && !en_q) begin
      en_q = 1'b1;
    end
    err = longint'($signed(b.actual_angle)) - longint'($signed(b.target_angle));
    drv = longint'(model_cfg.gain) * err / 25600;
    if (drv > 32767) drv = 32767;
    if (drv < -32768) drv = -32768;
    mag_err = (err < 0) ? -err : err;
    if (mag_err < Band) begin
      lim = (longint'(model_cfg.low_duty) * Band
             + mag_err * (longint'(model_cfg.high_duty) - longint'(model_cfg.low_duty))) / Band;
    end else begin
      lim = longint'(model_cfg.high_duty);
    end
    // The kick is added at full width, so the clamp below also acts as saturation.
    if (drv < 0) drv = drv - longint'(model_cfg.min_duty);
    else if (drv > 0) drv = drv + longint'(model_cfg.min_duty);
    if (drv > lim) drv = lim;
    if (drv < -lim) drv = -lim;
    if (model_cfg.invert_direction) drv = -drv;
    if (model_cfg.valve_mode) begin
      if (drv < -250) drv = -250;
      if (drv > 250) drv = 250;
      drv = (drv >>> 2) + 128;
    end
    if (b.steer_on) begin
      mag    = (drv < 0) ? -drv : drv;
      disp_q = DutyW'(mag);
      if (model_cfg.dir_plus_pwm_driver) begin
        left_q  = (drv >= 0) ? PwmFull : '0;
        right_q = PwmW'(mag * 4);
      end else if (drv > 0) begin
        right_q = '0;
        left_q  = PwmW'(drv * 4);
      end else begin
        left_q  = '0;
        right_q = PwmW'(mag * 4);
      end
    end
    r.enable_pin   = en_q;
    r.left_duty    = left_q;
    r.right_duty   = right_q;
    r.duty_display = disp_q;
    r.drive_value  = DriveW'(drv);
    return r;
  endfunction

  function automatic logic [DutyW-1:0] pick_duty();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      default: return DutyW'($urandom);
    endcase
  endfunction

  function automatic cfg_t random_cfg();
    cfg_t c;
    case ($urandom_range(0, 7))
      0:       c.gain = '0;
      1:       c.gain = '1;
      2, 3, 4: c.gain = GainW'($urandom_range(1, 4096));
      default: c.gain = GainW'($urandom);
    endcase
    c.low_duty            = pick_duty();
    c.high_duty           = pick_duty();
    c.min_duty            = pick_duty();
    c.invert_direction    = 1'($urandom_range(0, 1));
    c.valve_mode          = 1'($urandom_range(0, 1));
    c.dir_plus_pwm_driver = 1'($urandom_range(0, 1));
    return c;
  endfunction

  function automatic in_beat_t random_beat();
    in_beat_t b;
    int       tgt;
    int       act;
    int       sel;
    tgt = $signed(16'($urandom));
    sel = $urandom_range(0, 9);
    if (sel <= 5) begin
      // Errors around the ramp band are where the limit does its work.
      act = tgt + $urandom_range(0, 1400) - 700;
      if (act > 32767) act = 32767;
      if (act < -32768) act = -32768;
    end else if (sel <= 7) begin
      act = $signed(16'($urandom));
    end else if (sel == 8) begin
      case ($urandom_range(0, 3))
        0:       act = -32768;
        1:       act = 32767;
        2:       act = 0;
        default: act = -1;
      endcase
      tgt = ($urandom_range(0, 1) != 0) ? -32768 : 32767;
    end else begin
      act = tgt;
    end
    b.actual_angle = AngleW'(act);
    b.target_angle = AngleW'(tgt);
    b.steer_on     = ($urandom_range(0, 99) < 88);
    return b;
  endfunction

  function automatic void add_row(cfg_t c, int act, int tgt, bit on, bit typed, out_beat_t want);
    stim_row_t row;
    row.cfg                 = c;
    row.beat.actual_angle   = AngleW'(act);
    row.beat.target_angle   = AngleW'(tgt);
    row.beat.steer_on       = on;
    row.typed               = typed;
    row.want                = want;
    directed_rows.push_back(row);
  endfunction

  task automatic report_mismatch(string what, longint want, longint got);
    $display("mismatch at result %0d on %s: expected %0d, got %0d",
             result_cnt, what, want, got);
    err_cnt++;
  endtask

  // Lowers valid and waits until every expected beat has come out.
  task automatic drain();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
  endtask

  task automatic cfg_write(cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_cfg(cfg_t c);
    drain();
    cfg_write(CFG_GAIN,       c.gain);
    cfg_write(CFG_LOW_DUTY,   CfgDataW'(c.low_duty));
    cfg_write(CFG_HIGH_DUTY,  CfgDataW'(c.high_duty));
    cfg_write(CFG_MIN_DUTY,   CfgDataW'(c.min_duty));
    cfg_write(CFG_INVERT,     CfgDataW'(c.invert_direction));
    cfg_write(CFG_VALVE_MODE, CfgDataW'(c.valve_mode));
    cfg_write(CFG_DIR_PWM,    CfgDataW'(c.dir_plus_pwm_driver));
    cfg_we    <= 1'b0;
    model_cfg  = c;
  endtask

  task automatic send_beat(in_beat_t b, bit typed, out_beat_t want);
    out_beat_t pred;
    if (!quiet && $urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.actual_angle <= b.actual_angle;
    in_ch.target_angle <= b.target_angle;
    in_ch.steer_on     <= b.steer_on;
    do @(posedge clk); while (!in_ch.ready);
    pred = drive_predict(b);
    drive_q.push_back(typed ? want : pred);
  endtask

  // Result side: random stalls, one long hold on request, and the checker.
  initial begin : result_side
    int        stall_left;
    int        hold_seen;
    out_beat_t want;
    stall_left = 0;
    hold_seen  = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          $display("result %0d arrived with nothing expected", result_cnt);
          err_cnt++;
        end else begin
          want = drive_q.pop_front();
          if (out_ch.enable_pin !== want.enable_pin)
            report_mismatch("enable_pin", longint'(want.enable_pin),
                            longint'(out_ch.enable_pin));
          if (out_ch.left_duty !== want.left_duty)
            report_mismatch("left_duty", longint'(want.left_duty),
                            longint'(out_ch.left_duty));
          if (out_ch.right_duty !== want.right_duty)
            report_mismatch("right_duty", longint'(want.right_duty),
                            longint'(out_ch.right_duty));
          if (out_ch.duty_display !== want.duty_display)
            report_mismatch("duty_display", longint'(want.duty_display),
                            longint'(out_ch.duty_display));
          if (out_ch.drive_value !== want.drive_value)
            report_mismatch("drive_value", longint'(want.drive_value),
                            longint'(out_ch.drive_value));
        end
        result_cnt++;
      end
      if (hold_seen != hold_req) begin
        hold_seen  = hold_req;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("proportional_steer_pwm_drive_core_tb: errors");
    $finish;
  end

  initial begin : stimulus
    cfg_t rst_cfg;
    cfg_t cfg_a;
    cfg_t cfg_b;
    cfg_t cfg_c;
    cfg_t cfg_d;
    cfg_t cfg_e;
    cfg_t c;
    err_cnt    = 0;
    result_cnt = 0;
    cycle_cnt  = 0;
    idle_pct   = 15;
    quiet      = 1'b0;
    hold_req   = 0;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_idx            <= CFG_GAIN;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.actual_angle <= '0;
    in_ch.target_angle <= '0;
    in_ch.steer_on     <= 1'b0;

    rst_cfg   = '{16'd0, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0};
    cfg_a     = '{16'hFFFF, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b0};
    cfg_b     = '{16'd256, 8'd20, 8'd200, 8'd10, 1'b0, 1'b0, 1'b0};
    cfg_c     = '{16'hFFFF, 8'd200, 8'd50, 8'd255, 1'b0, 1'b0, 1'b0};
    cfg_d     = '{16'hFFFF, 8'd0, 8'd255, 8'd0, 1'b1, 1'b1, 1'b0};
    cfg_e     = '{16'hFFFF, 8'd0, 8'd255, 8'd0, 1'b0, 1'b0, 1'b1};
    model_cfg = rst_cfg;
    en_q      = 1'b0;
    left_q    = '0;
    right_q   = '0;
    disp_q    = '0;

    // Register defaults straight after reset.
    add_row(rst_cfg, 0, 0, 1'b0, 1'b1, '{1'b0, 10'd0, 10'd0, 8'd0, 9'sd0});
    add_row(rst_cfg, 32767, -32768, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd0, 8'd0, 9'sd0});
    // Full gain, widest errors, zero drive, then steering switched off.
    add_row(cfg_a, 32767, -32768, 1'b1, 1'b1, '{1'b1, 10'd1020, 10'd0, 8'd255, 9'sd255});
    add_row(cfg_a, -32768, 32767, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd1020, 8'd255, -9'sd255});
    add_row(cfg_a, 100, 100, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd0, 8'd0, 9'sd0});
    add_row(cfg_a, 32767, 0, 1'b0, 1'b1, '{1'b0, 10'd0, 10'd0, 8'd0, 9'sd255});
    add_row(cfg_a, 0, 0, 1'b0, 1'b1, '{1'b0, 10'd0, 10'd0, 8'd0, 9'sd0});
    // Ramp edges, truncation toward zero and the kick.
    add_row(cfg_b, 150, 0, 1'b1, 1'b0, '0);
    add_row(cfg_b, 0, 150, 1'b1, 1'b0, '0);
    add_row(cfg_b, 1, 0, 1'b1, 1'b0, '0);
    add_row(cfg_b, -100, 0, 1'b1, 1'b0, '0);
    add_row(cfg_b, 299, 0, 1'b1, 1'b0, '0);
    add_row(cfg_b, -300, 0, 1'b1, 1'b0, '0);
    add_row(cfg_b, 0, -32768, 1'b0, 1'b0, '0);
    // Descending ramp with the largest kick.
    add_row(cfg_c, 299, 0, 1'b1, 1'b0, '0);
    add_row(cfg_c, 1, 0, 1'b1, 1'b0, '0);
    add_row(cfg_c, -1, 0, 1'b1, 1'b0, '0);
    add_row(cfg_c, 300, 0, 1'b1, 1'b0, '0);
    // Inverted valve mapping at both ends and at zero.
    add_row(cfg_d, 32767, -32768, 1'b1, 1'b1, '{1'b1, 10'd260, 10'd0, 8'd65, 9'sd65});
    add_row(cfg_d, -32768, 32767, 1'b1, 1'b1, '{1'b1, 10'd760, 10'd0, 8'd190, 9'sd190});
    add_row(cfg_d, 5, 5, 1'b1, 1'b1, '{1'b1, 10'd512, 10'd0, 8'd128, 9'sd128});
    // Direction plus PWM style.
    add_row(cfg_e, 32767, -32768, 1'b1, 1'b1, '{1'b1, 10'd1023, 10'd1020, 8'd255, 9'sd255});
    add_row(cfg_e, -32768, 32767, 1'b1, 1'b1, '{1'b1, 10'd0, 10'd1020, 8'd255, -9'sd255});
    add_row(cfg_e, 0, 0, 1'b1, 1'b1, '{1'b1, 10'd1023, 10'd0, 8'd0, 9'sd0});

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].cfg !== model_cfg) apply_cfg(directed_rows[i].cfg);
      send_beat(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph == 0)      c = '{16'hFFFF, 8'd255, 8'd255, 8'd255, 1'b1, 1'b1, 1'b1};
      else if (ph == 1) c = '{16'd0, 8'd0, 8'd0, 8'd0, 1'b0, 1'b0, 1'b0};
      else              c = random_cfg();
      apply_cfg(c);
      idle_pct = (ph == 3) ? 0 : 15;
      quiet    = (ph == NumPhases - 1);
      // The receiver holds off long enough that the pipeline backs up into the input.
      if (ph == 2) hold_req++;
      for (int n = 0; n < PhaseBeats; n++) send_beat(random_beat(), 1'b0, '0);
    end

    drain();
    repeat (10) @(posedge clk);
    if (err_cnt == 0) begin
      $display("proportional_steer_pwm_drive_core_tb: clean");
    end else begin
      $display("proportional_steer_pwm_drive_core_tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/psd_pkg.sv
rtl/psd_in_if.sv
rtl/psd_out_if.sv
rtl/psd_front.sv
rtl/psd_scale.sv
rtl/psd_drive.sv
rtl/proportional_steer_pwm_drive_core.sv
verif/proportional_steer_pwm_drive_core_tb.sv
